/* rtl/core/brpk_pkg.sv */
// Shared types and constants for the ByteRun1 row packer.
package brpk_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int STORE_AW    = 7;
  localparam int MIN_RUN     = 3;
  localparam int SIZE_W      = 13;

  // One packet to send: literal (header + len store bytes) or run (header + value).
  typedef struct packed {
    logic       vld;
    logic       is_run;
    logic [7:0] len;
    logic [7:0] value;
  } packet_t;

  // Work for one accepted byte.
  typedef struct packed {
    packet_t               pkt_a;
    packet_t               pkt_b;
    logic                  wr_en;
    logic [STORE_AW-1:0]   wr_idx;
    logic [7:0]            value;
  } plan_t;

  // One byte in flight from the sequencer to the word assembler.
  typedef struct packed {
    logic       vld;
    logic       from_mem;
    logic [7:0] imm;
    logic       final_byte;
    logic       row_end;
  } byte_req_t;

endpackage

/* rtl/core/byterun1_row_packer.sv */
// Top level of the ByteRun1 (PackBits) row packer.
//
// Slave side: one raw byte per request on s_tdata, s_tlast marks the last byte
// of a row. Master side: up to eight packed bytes per word (first stream byte in
// bits 7:0, unused lanes zero), the byte count, and the packed row size so far;
// m_tuser flags the last word caused by an input byte, m_tlast the word that
// closes a row, where the size field holds the row total (saturating).
// A byte that closes no packet is accepted and then written to the store. Each
// packet a byte closes adds a header step and one step per body byte (one for a
// run, n for a literal of n, read from the literal store), plus a pause for each
// output word that fills while bytes remain to walk. A word shows on m_tvalid
// once its last byte has passed the request register and the output register.
// s_tready is high only while no packet walk is in progress. Reset clears the
// row state and empties the output register; the literal store needs no
// clearing since only entries written in the current row are read. When the
// receiver stalls, the word waits in the output register and the packet walk
// pauses; no byte is dropped.
module byterun1_row_packer #(
  parameter int MAX_LITERAL   = 128,
  parameter int MAX_RUN_LEN   = 128,
  parameter int MAX_ROW_BYTES = 4096,
  parameter int OUT_LANES     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // raw_byte
  input  logic        s_tlast,   // row_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // packed_bytes[63:0], byte_count[67:64], packed_size[80:68]
  output logic        m_tuser,   // last_of_item
  output logic        m_tlast    // row_done
);
  import brpk_pkg::*;

  plan_t             plan;
  logic [SIZE_W-1:0] size_so_far;
  logic              take;
  logic              idle;
  logic              go;
  byte_req_t         req;
  logic [7:0]        rd_data;

  assign s_tready = idle;
  assign take     = s_tvalid && idle;

  brpk_planner #(
    .MAX_LITERAL   (MAX_LITERAL),
    .MAX_RUN_LEN   (MAX_RUN_LEN),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_planner (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .raw_byte    (s_tdata),
    .row_end     (s_tlast),
    .plan        (plan),
    .size_so_far (size_so_far)
  );

  brpk_sequencer u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .load    (take),
    .plan_in (plan),
    .go      (go),
    .idle    (idle),
    .req     (req),
    .rd_data (rd_data)
  );

  brpk_assembler #(
    .OUT_LANES (OUT_LANES)
  ) u_assembler (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rd_data     (rd_data),
    .size_so_far (size_so_far),
    .go          (go),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

/* rtl/core/brpk_planner.sv */
// Packing decisions per input byte and the scalar row state.
module brpk_planner #(
  parameter int MAX_LITERAL   = 128,
  parameter int MAX_RUN_LEN   = 128,
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [7:0]                   raw_byte,
  input  logic                         row_end,
  output brpk_pkg::plan_t              plan,
  output logic [brpk_pkg::SIZE_W-1:0]  size_so_far
);
  import brpk_pkg::*;

  localparam int SizeCap = MAX_ROW_BYTES + MAX_ROW_BYTES / 64;

  logic [7:0]          held_count, held_next;
  logic [STORE_AW-1:0] run_begin, run_begin_next;
  logic [7:0]          previous_byte;
  logic                in_run, in_run_next;
  logic                row_open;
  logic [SIZE_W-1:0]   size_base, size_next;
  logic [7:0]          held_inc;
  logic [8:0]          bytes_a, bytes_b;
  logic [SIZE_W:0]     size_sum;

  function automatic logic [8:0] pkt_bytes(input packet_t p);
    logic [8:0] n;
    n = 9'd0;
    if (p.vld) begin
      n = p.is_run ? 9'd2 : ({1'b0, p.len} + 9'd1);
    end
    return n;
  endfunction

  always_comb begin
    plan           = '0;
    plan.value     = raw_byte;
    held_next      = held_count;
    run_begin_next = run_begin;
    in_run_next    = in_run;
    size_base      = size_so_far;
    held_inc       = held_count + 8'd1;
    if (!row_open) begin
      held_next      = 8'd1;
      run_begin_next = '0;
      in_run_next    = 1'b0;
      size_base      = '0;
      plan.wr_en     = 1'b1;
    end else if (in_run) begin
      if (raw_byte != previous_byte || held_count >= 8'(MAX_RUN_LEN)) begin
        plan.pkt_a.vld    = 1'b1;
        plan.pkt_a.is_run = 1'b1;
        plan.pkt_a.len    = held_count;
        plan.pkt_a.value  = previous_byte;
        held_next         = 8'd1;
        run_begin_next    = '0;
        in_run_next       = 1'b0;
        plan.wr_en        = 1'b1;
      end else begin
        held_next = held_inc;
      end
    end else if (held_count >= 8'(MAX_LITERAL)) begin
      // store full: flush it whole, the new byte opens the next literal
      plan.pkt_a.vld = 1'b1;
      plan.pkt_a.len = held_count;
      held_next      = 8'd1;
      run_begin_next = '0;
      plan.wr_en     = 1'b1;
    end else begin
      plan.wr_en  = 1'b1;
      plan.wr_idx = held_count[STORE_AW-1:0];
      held_next   = held_inc;
      if (raw_byte == previous_byte) begin
        if (held_inc - {1'b0, run_begin} >= 8'(MIN_RUN)) begin
          if (run_begin != '0) begin
            plan.pkt_a.vld = 1'b1;
            plan.pkt_a.len = {1'b0, run_begin};
            held_next      = held_inc - {1'b0, run_begin};
            run_begin_next = '0;
          end
          in_run_next = 1'b1;
        end else if (run_begin == '0) begin
          in_run_next = 1'b1;
        end
      end else begin
        run_begin_next = held_count[STORE_AW-1:0];
      end
    end

    if (row_end) begin
      plan.pkt_b.vld    = 1'b1;
      plan.pkt_b.is_run = in_run_next;
      plan.pkt_b.len    = held_next;
      plan.pkt_b.value  = raw_byte;
    end

    bytes_a  = pkt_bytes(plan.pkt_a);
    bytes_b  = pkt_bytes(plan.pkt_b);
    size_sum = {1'b0, size_base} + (SIZE_W+1)'(bytes_a) + (SIZE_W+1)'(bytes_b);
    size_next = (size_sum >= (SIZE_W+1)'(SizeCap)) ? SIZE_W'(SizeCap)
                                                    : size_sum[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      run_begin     <= '0;
      previous_byte <= '0;
      in_run        <= 1'b0;
      row_open      <= 1'b0;
      size_so_far   <= '0;
    end else if (take) begin
      held_count    <= row_end ? 8'd0 : held_next;
      run_begin     <= row_end ? '0 : run_begin_next;
      in_run        <= row_end ? 1'b0 : in_run_next;
      row_open      <= !row_end;
      previous_byte <= raw_byte;
      size_so_far   <= size_next;
    end
  end

endmodule

/* rtl/core/brpk_sequencer.sv */
// Literal store memory and the byte sequencer that walks the packets of one request.
module brpk_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  brpk_pkg::plan_t     plan_in,
  input  logic                go,
  output logic                idle,
  output brpk_pkg::byte_req_t req,
  output logic [7:0]          rd_data
);
  import brpk_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_A_HDR  = 6'b000010,
    ST_A_BODY = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_B_HDR  = 6'b010000,
    ST_B_BODY = 6'b100000
  } seq_state_t;

  seq_state_t          state, state_next;
  plan_t               plan;
  logic [STORE_AW-1:0] idx, idx_next;
  logic [7:0]          store [STORE_DEPTH];
  logic                wr;
  byte_req_t           req_next;
  packet_t             cur;
  logic                b_phase;
  logic                final_pkt;
  logic                body_end;
  logic [7:0]          hdr;
  logic [8:0]          run_hdr;

  assign idle      = (state == ST_IDLE);
  assign b_phase   = (state == ST_B_HDR) || (state == ST_B_BODY);
  assign cur       = b_phase ? plan.pkt_b : plan.pkt_a;
  assign final_pkt = b_phase || !plan.pkt_b.vld;
  assign body_end  = cur.is_run || (idx == STORE_AW'(cur.len - 8'd1));
  assign run_hdr   = 9'd257 - {1'b0, cur.len};
  assign hdr       = cur.is_run ? run_hdr[7:0] : (cur.len - 8'd1);

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    wr               = 1'b0;
    req_next         = '0;
    req_next.row_end = plan.pkt_b.vld;
    case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = plan_in.pkt_a.vld ? ST_A_HDR : ST_WRITE;
        end
      end
      ST_A_HDR, ST_B_HDR: begin
        if (go) begin
          req_next.vld = 1'b1;
          req_next.imm = hdr;
          idx_next     = '0;
          state_next   = b_phase ? ST_B_BODY : ST_A_BODY;
        end
      end
      ST_A_BODY, ST_B_BODY: begin
        if (go) begin
          req_next.vld        = 1'b1;
          req_next.from_mem   = !cur.is_run;
          req_next.imm        = cur.value;
          req_next.final_byte = body_end && final_pkt;
          if (body_end) begin
            state_next = b_phase ? ST_IDLE : ST_WRITE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_WRITE: begin
        // new byte lands after packet A has read the old contents
        wr         = plan.wr_en;
        state_next = plan.pkt_b.vld ? ST_B_HDR : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      req.vld <= 1'b0;
    end else begin
      state <= state_next;
      req   <= req_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (load && idle) begin
      plan <= plan_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      store[plan.wr_idx] <= plan.value;
    end
    rd_data <= store[idx];
  end

endmodule

/* rtl/core/brpk_assembler.sv */
// Gathers packed bytes into output words and holds the output register.
module brpk_assembler #(
  parameter int OUT_LANES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  brpk_pkg::byte_req_t          req,
  input  logic [7:0]                   rd_data,
  input  logic [brpk_pkg::SIZE_W-1:0]  size_so_far,
  output logic                         go,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [87:0]                  m_tdata,  // packed_bytes, byte_count, packed_size
  output logic                         m_tuser,  // last_of_item
  output logic                         m_tlast   // row_done
);
  import brpk_pkg::*;

  logic [63:0]       acc, acc_next;
  logic [2:0]        cnt;
  logic [7:0]        cur_byte;
  logic              flush_now;
  logic [63:0]       out_data;
  logic [3:0]        out_cnt;
  logic [SIZE_W-1:0] out_size;

  assign cur_byte  = req.from_mem ? rd_data : req.imm;
  assign acc_next  = acc | (64'(cur_byte) << {cnt, 3'b000});
  assign flush_now = req.vld && (cnt == 3'(OUT_LANES - 1) || req.final_byte);
  // a new byte is issued only if its arrival can never find the output register busy
  assign go        = (!m_tvalid || m_tready) && !flush_now;

  assign m_tdata = {7'd0, out_size, out_cnt, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (flush_now) begin
        acc      <= '0;
        cnt      <= '0;
        m_tvalid <= 1'b1;
      end else begin
        if (req.vld) begin
          acc <= acc_next;
          cnt <= cnt + 3'd1;
        end
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush_now) begin
      out_data <= acc_next;
      out_cnt  <= {1'b0, cnt} + 4'd1;
      m_tuser  <= req.final_byte;
      m_tlast  <= req.final_byte && req.row_end;
      out_size <= size_so_far;
    end
  end

endmodule
